FILE: rtl/core/mbssd_pkg.sv
// Package for the masked byte SSD accumulator: lane geometry, field widths,
// configuration register indexes and the structs shared by the core modules.
// No dependencies.
`timescale 1ns / 1ps

package mbssd_pkg;

    // lane geometry and field widths
    localparam int LANES      = 8;
    localparam int PIX_W      = 8;
    localparam int DATA_W     = LANES * PIX_W;
    localparam int COUNT_W    = 4;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int GROUP_W    = SQ_W + $clog2(LANES + 1);
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [SQ_W-1:0]    square_t;
    typedef logic [GROUP_W-1:0] group_sum_t;
    typedef logic [ACC_W-1:0]   acc_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_ENABLE = 2'd0,
        CFG_MASK_INDEX  = 2'd1
    } cfg_index_t;

    // configuration seen by every lane
    typedef struct packed {
        logic   mask_enable;
        pixel_t mask_index;
    } cfg_t;

    // control of the beat held in the lane stage
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctrl_t;

endpackage

FILE: rtl/core/mbssd_lane.sv
// One pixel lane: mask test, absolute difference and square, registered.
// Depends on mbssd_pkg.
`timescale 1ns / 1ps

module mbssd_lane (
    input  logic              aclk,
    input  logic              load,
    input  mbssd_pkg::cfg_t   cfg,
    input  logic              lane_on,
    input  mbssd_pkg::pixel_t a_pix,
    input  mbssd_pkg::pixel_t b_pix,
    input  mbssd_pkg::pixel_t mask_pix,
    output mbssd_pkg::square_t square
);

    mbssd_pkg::pixel_t  diff;
    logic               counts;
    mbssd_pkg::square_t square_next;
    mbssd_pkg::square_t square_reg;

    // decide whether the lane contributes
    assign counts = lane_on && (!cfg.mask_enable || (mask_pix == cfg.mask_index));

    // square the absolute difference, zero for a dropped lane
    always_comb begin
        diff        = (a_pix >= b_pix) ? (a_pix - b_pix) : (b_pix - a_pix);
        square_next = counts ? (mbssd_pkg::SQ_W'(diff) * mbssd_pkg::SQ_W'(diff)) : '0;
    end

    // hold the square until the next accepted beat
    always_ff @(posedge aclk) begin
        if (load) begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

FILE: rtl/core/mbssd_merge.sv
// Merge stage: sums the lane squares of a beat, accumulates the region total
// and holds the result beat in the output register. Depends on mbssd_pkg.
`timescale 1ns / 1ps

module mbssd_merge (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  mbssd_pkg::beat_ctrl_t                       s1,
    input  mbssd_pkg::square_t [mbssd_pkg::LANES-1:0]   squares,
    output logic                                        s1_ready,
    input  logic                                        m_ready,
    output logic                                        m_valid,
    output mbssd_pkg::acc_t                             m_total
);

    mbssd_pkg::group_sum_t group_sum_next;
    mbssd_pkg::group_sum_t s2_sum_reg;
    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_last_reg;
    mbssd_pkg::acc_t       acc_reg, acc_next;
    mbssd_pkg::acc_t       acc_sum;
    logic                  m_valid_reg, m_valid_next;
    mbssd_pkg::acc_t       m_total_reg;
    logic                  out_free;
    logic                  s2_go;
    logic                  s2_load;

    // add the lane squares of one beat
    always_comb begin
        group_sum_next = '0;
        for (int i = 0; i < mbssd_pkg::LANES; i++) begin
            group_sum_next = group_sum_next + mbssd_pkg::GROUP_W'(squares[i]);
        end
    end

    // advance the sum stage when the accumulator can take its beat
    assign out_free = !m_valid_reg || m_ready;
    assign s2_go    = s2_valid_reg && (!s2_last_reg || out_free);
    assign s1_ready = !s2_valid_reg || s2_go;
    assign s2_load  = s1.valid && s1_ready;

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s2_load) begin
            s2_valid_next = 1'b1;
        end else if (s2_go) begin
            s2_valid_next = 1'b0;
        end
    end

    // accumulate, emit and clear on the last beat
    assign acc_sum = acc_reg + mbssd_pkg::ACC_W'(s2_sum_reg);

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s2_go) begin
            if (s2_last_reg) begin
                acc_next     = '0;
                m_valid_next = 1'b1;
            end else begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            acc_reg      <= acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_sum_reg  <= group_sum_next;
            s2_last_reg <= s1.last;
        end
        if (s2_go && s2_last_reg) begin
            m_total_reg <= acc_sum;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_total = m_total_reg;

endmodule

FILE: rtl/core/masked_byte_ssd_accumulator.sv
// Top level of the masked byte SSD accumulator: configuration registers,
// lane stage control, LANES lane instances and the merge stage.
// Depends on mbssd_pkg, mbssd_lane and mbssd_merge.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_a_pixels s_b_pixels s_mask_bytes
//                                          s_lane_count s_last
//   m_       out        m_valid / m_ready  m_total
//   cfg_     in         cfg_we             cfg_index cfg_wdata
//
// One beat is accepted every cycle while s_ready is high. A beat marked last
// shows its total on m_valid after it passes the lane squares, group sum and accumulate steps.
// aresetn (synchronous) clears the accumulator, both registers and all valids.
// A stall on m_ready backs up only behind a waiting last beat; beats that are
// not last keep flowing into the accumulator while the result waits.
`timescale 1ns / 1ps

module masked_byte_ssd_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mbssd_pkg::DATA_W-1:0]        s_a_pixels,
    input  logic [mbssd_pkg::DATA_W-1:0]        s_b_pixels,
    input  logic [mbssd_pkg::DATA_W-1:0]        s_mask_bytes,
    input  logic [mbssd_pkg::COUNT_W-1:0]       s_lane_count,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mbssd_pkg::ACC_W-1:0]         m_total,
    input  logic                                cfg_we,
    input  logic [mbssd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbssd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    mbssd_pkg::cfg_t                            cfg_reg, cfg_next;
    logic                                       s1_valid_reg, s1_valid_next;
    logic                                       s1_last_reg;
    logic                                       s1_ready;
    logic                                       s_fire;
    mbssd_pkg::beat_ctrl_t                      s1_ctrl;
    mbssd_pkg::square_t [mbssd_pkg::LANES-1:0]  squares;
    logic [mbssd_pkg::LANES-1:0]                lane_on;

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                mbssd_pkg::CFG_MASK_ENABLE: cfg_next.mask_enable = cfg_wdata[0];
                mbssd_pkg::CFG_MASK_INDEX:  cfg_next.mask_index  = cfg_wdata[mbssd_pkg::PIX_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // lane stage handshake
    assign s_ready = !s1_valid_reg || s1_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_last_reg <= s_last;
        end
    end

    assign s1_ctrl.valid = s1_valid_reg;
    assign s1_ctrl.last  = s1_last_reg;

    // lanes: a count above LANES enables every lane
    for (genvar i = 0; i < mbssd_pkg::LANES; i++) begin : g_lane
        assign lane_on[i] = (s_lane_count > mbssd_pkg::COUNT_W'(i));

        mbssd_lane u_lane (
            .aclk     (aclk),
            .load     (s_fire),
            .cfg      (cfg_reg),
            .lane_on  (lane_on[i]),
            .a_pix    (s_a_pixels[i*mbssd_pkg::PIX_W +: mbssd_pkg::PIX_W]),
            .b_pix    (s_b_pixels[i*mbssd_pkg::PIX_W +: mbssd_pkg::PIX_W]),
            .mask_pix (s_mask_bytes[i*mbssd_pkg::PIX_W +: mbssd_pkg::PIX_W]),
            .square   (squares[i])
        );
    end

    // merge lanes and accumulate
    mbssd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1_ctrl),
        .squares  (squares),
        .s1_ready (s1_ready),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_total  (m_total)
    );

endmodule

FILE: rtl/core/mbssd_checker.sv
// Port-level checker for the masked byte SSD accumulator, bound to the top.
// Depends on the top level's port names only.
`timescale 1ns / 1ps

module mbssd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    // with the output register empty the block always takes a beat
    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready
    ) else $error("s_ready low while no result is waiting");

    // input backpressure only comes from a stalled result
    a_stall_from_output: assert property (
        @(posedge aclk) disable iff (!aresetn) !s_ready |-> (m_valid && !m_ready)
    ) else $error("s_ready low without a stalled result beat");

    // a stalled result beat stays
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |=> m_valid
    ) else $error("result beat dropped before acceptance");

endmodule

bind masked_byte_ssd_accumulator mbssd_checker u_mbssd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
